// ===== src/trial_division_factorizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// Trial division factorizer assertion macros
// Concurrent assertion shorthands clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_FACTORIZER_TOP_ASSERT_SVH
`define TRIAL_DIVISION_FACTORIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/trdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Trial division factorizer package
// Field widths and parameter defaults shared by the factorizer.
// ----------------------------------------------------------------------------
package trdf_pkg;

    localparam int FIELD_BITS         = 48;
    localparam int EXP_BITS           = 6;
    localparam int DEFAULT_VALUE_BITS = 48;

endpackage

// ===== src/trial_division_factorizer_top.sv =====
// ----------------------------------------------------------------------------
// Trial division factorizer
// Emits the prime factorization of each input value as a run of transactions.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  input   | in        | i_in_valid / o_in_stall   | i_value
//  output  | out       | o_out_valid / i_out_stall | o_prime, o_exponent, o_last
//
// One shared restoring divider produces one quotient bit per cycle, and each
// division ends in a decision state. The divider width W is the smaller of
// VALUE_BITS and 48. Each trial divisor costs one division that leaves a
// remainder plus one more for every time it divides evenly.
// Reset is synchronous and active low.
// A stalled output holds the sequencer only when it has a result to hand over.
// The next input transaction is taken while the last result still waits.
// ----------------------------------------------------------------------------
module trial_division_factorizer_top #(
    parameter int VALUE_BITS = trdf_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [trdf_pkg::FIELD_BITS-1:0] i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [trdf_pkg::FIELD_BITS-1:0] o_prime,
    output logic [trdf_pkg::EXP_BITS-1:0]   o_exponent,
    output logic                            o_last
);

    import trdf_pkg::*;

    `include "trial_division_factorizer_top_assert.svh"

    localparam int W  = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int DW = (W + 1) / 2 + 1;
    localparam int SW = $clog2(W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_DECIDE,
        S_END,
        S_ONE
    } t_state;

    t_state              r_state,       n_state;
    logic [W-1:0]        r_n,           n_n;
    logic [W-1:0]        r_quo,         n_quo;
    logic [DW-1:0]       r_rem,         n_rem;
    logic [DW-1:0]       r_div,         n_div;
    logic [SW-1:0]       r_step,        n_step;
    logic [EXP_BITS-1:0] r_cnt,         n_cnt;
    logic                r_first,       n_first;
    logic [W-1:0]        r_held_prime,  n_held_prime;
    logic [EXP_BITS-1:0] r_held_exp,    n_held_exp;
    logic                r_held_valid,  n_held_valid;
    logic                r_out_valid,   n_out_valid;
    logic [W-1:0]        r_out_prime,   n_out_prime;
    logic [EXP_BITS-1:0] r_out_exp,     n_out_exp;
    logic                r_out_last,    n_out_last;

    logic [W-1:0]        in_n;
    logic [DW:0]         rem_sh;
    logic [DW:0]         diff;
    logic                qbit;
    logic                out_free;
    logic                advance;

    assign in_n     = i_value[W-1:0];
    assign rem_sh   = {r_rem, r_quo[W-1]};
    assign diff     = rem_sh - {1'b0, r_div};
    assign qbit     = ~diff[DW];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_step       = r_step;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_held_prime = r_held_prime;
        n_held_exp   = r_held_exp;
        n_held_valid = r_held_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_prime  = r_out_prime;
        n_out_exp    = r_out_exp;
        n_out_last   = r_out_last;
        advance      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n = in_n;
                    if (in_n <= W'(1)) begin
                        n_state = S_ONE;
                    end else begin
                        n_quo        = in_n;
                        n_rem        = '0;
                        n_step       = '0;
                        n_div        = DW'(2);
                        n_cnt        = '0;
                        n_first      = 1'b1;
                        n_held_valid = 1'b0;
                        n_state      = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
                n_quo  = {r_quo[W-2:0], qbit};
                n_step = r_step + SW'(1);
                if (r_step == SW'(W - 1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_first && (W'(r_div) > r_quo)) begin
                    n_state = S_END;
                end else if (r_rem == '0) begin
                    n_n     = r_quo;
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = r_cnt + EXP_BITS'(1);
                    n_first = 1'b0;
                    n_state = S_DIV;
                end else if (r_cnt != '0) begin
                    if (!r_held_valid || out_free) begin
                        if (r_held_valid) begin
                            n_out_valid = 1'b1;
                            n_out_prime = r_held_prime;
                            n_out_exp   = r_held_exp;
                            n_out_last  = 1'b0;
                        end
                        n_held_prime = W'(r_div);
                        n_held_exp   = r_cnt;
                        n_held_valid = 1'b1;
                        advance      = 1'b1;
                    end
                end else begin
                    advance = 1'b1;
                end
                if (advance) begin
                    n_div   = (r_div == DW'(2)) ? DW'(3) : r_div + DW'(2);
                    n_cnt   = '0;
                    n_first = 1'b1;
                    n_quo   = r_n;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end
            S_END: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_n > W'(1)) begin
                        if (r_held_valid) begin
                            n_out_prime  = r_held_prime;
                            n_out_exp    = r_held_exp;
                            n_out_last   = 1'b0;
                            n_held_valid = 1'b0;
                        end else begin
                            n_out_prime = r_n;
                            n_out_exp   = EXP_BITS'(1);
                            n_out_last  = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_out_prime  = r_held_prime;
                        n_out_exp    = r_held_exp;
                        n_out_last   = 1'b1;
                        n_held_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_ONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_prime = '0;
                    n_out_exp   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_step       <= n_step;
        r_cnt        <= n_cnt;
        r_first      <= n_first;
        r_held_prime <= n_held_prime;
        r_held_exp   <= n_held_exp;
        r_out_prime  <= n_out_prime;
        r_out_exp    <= n_out_exp;
        r_out_last   <= n_out_last;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_prime     = FIELD_BITS'(r_out_prime);
    assign o_exponent  = r_out_exp;
    assign o_last      = r_out_last;

    `TDF_ASSERT_SAME(a_idle_nothing_held, r_state == S_IDLE, !r_held_valid,
        "A result is still held while the sequencer is idle.")
    `TDF_ASSERT_SAME(a_zero_prime_is_last, r_out_valid && (r_out_prime == '0),
        r_out_last && (r_out_exp == '0), "A zero prime is not the lone last result.")
    `TDF_ASSERT_SAME(a_prime_has_exponent, r_out_valid && (r_out_prime != '0),
        r_out_exp != '0, "A prime factor carries a zero exponent.")
    `TDF_ASSERT_SAME(a_divisor_above_one, r_state == S_DIV, r_div >= DW'(2),
        "The trial divisor dropped below two.")
    `TDF_ASSERT_NEXT(a_stalled_output_holds, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_out_prime) && $stable(r_out_last),
        "A stalled output transaction changed.")

endmodule

// ===== tb/sv/trial_division_factorizer_top_test.sv =====
// ----------------------------------------------------------------------------
// Trial division factorizer testbench
// Sends integers to the factorizer and compares each (prime, exponent, last)
// transaction with a local factorization, under random idling on both sides.
// ----------------------------------------------------------------------------
module trial_division_factorizer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import trdf_pkg::*;

    localparam int          DRAIN_CYCLES  = 200;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [63:0] VALUE_MASK    = (64'd1 << DEFAULT_VALUE_BITS) - 64'd1;
    localparam logic [63:0] FIELD_MASK    = (64'd1 << FIELD_BITS) - 64'd1;
    localparam logic [63:0] FIELD_LIMIT   = 64'd1 << FIELD_BITS;

    typedef struct packed {
        logic [FIELD_BITS-1:0] prime;
        logic [EXP_BITS-1:0]   exponent;
        logic                  last;
    } factor_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [FIELD_BITS-1:0] i_value     = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [FIELD_BITS-1:0] o_prime;
    logic [EXP_BITS-1:0]   o_exponent;
    logic                  o_last;

    factor_t expected_factors[$];
    int      fail_count = 0;
    bit      offering   = 1'b0;

    int hold_serial = 0;
    int hold_seen   = 0;
    int hold_len    = 0;
    int stall_left  = 0;
    int run_left    = 0;

    trial_division_factorizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_prime     (o_prime),
        .o_exponent  (o_exponent),
        .o_last      (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic int pick_run();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 8);
        return $urandom_range(50, 400);
    endfunction

    function automatic void note_failure(string what, factor_t want, factor_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s: expected prime %0d exponent %0d last %0d,",
                     what, want.prime, want.exponent, want.last,
                     " got prime %0d exponent %0d last %0d",
                     got.prime, got.exponent, got.last);
        end
    endfunction

    // Builds the expected run of transactions for one accepted integer.
    function automatic void factorize_value(input logic [FIELD_BITS-1:0] value);
        logic [63:0] rest;
        logic [63:0] divisor;
        logic [63:0] multiplicity;
        factor_t     run[$];
        factor_t     item;
        rest = {16'd0, value} & VALUE_MASK & FIELD_MASK;
        if (rest <= 64'd1) begin
            item.prime    = '0;
            item.exponent = '0;
            item.last     = 1'b1;
            expected_factors = {expected_factors, item};
            return;
        end
        divisor = 64'd2;
        while (divisor <= rest / divisor) begin
            multiplicity = 64'd0;
            while (rest % divisor == 64'd0) begin
                rest = rest / divisor;
                multiplicity++;
            end
            if (multiplicity != 64'd0) begin
                item.prime    = divisor[FIELD_BITS-1:0];
                item.exponent = multiplicity[EXP_BITS-1:0];
                item.last     = 1'b0;
                run = {run, item};
            end
            divisor = (divisor == 64'd2) ? 64'd3 : divisor + 64'd2;
        end
        if (rest > 64'd1) begin
            item.prime    = rest[FIELD_BITS-1:0];
            item.exponent = EXP_BITS'(1);
            item.last     = 1'b0;
            run = {run, item};
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[i]) expected_factors = {expected_factors, run[i]};
    endfunction

    function automatic void check_factor(factor_t got);
        factor_t want;
        if (expected_factors.size() == 0) begin
            want = '0;
            note_failure("unexpected transaction", want, got);
            return;
        end
        want = expected_factors.pop_front();
        if (want.prime !== got.prime || want.exponent !== got.exponent ||
            want.last !== got.last) begin
            note_failure("mismatch", want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_factor('{prime: o_prime, exponent: o_exponent, last: o_last});
        end
    end

    // Output stall driver; a long hold-off requested by a test is counted here.
    always @(posedge i_clk) begin
        if (hold_seen != hold_serial) begin
            hold_seen   <= hold_serial;
            stall_left  <= hold_len;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left    <= run_left - 1;
            i_out_stall <= 1'b0;
        end else begin
            stall_left  <= pick_gap();
            run_left    <= pick_run();
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_value(input logic [FIELD_BITS-1:0] value, input bit with_gaps);
        int gap;
        gap = with_gaps ? pick_gap() : 0;
        if (!offering && gap == 0) gap = 1;
        if (gap > 0) begin
            if (offering) i_in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        offering = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        factorize_value(value);
    endtask

    task automatic stop_offering();
        if (offering) i_in_valid <= 1'b0;
        offering = 1'b0;
    endtask

    task automatic wait_for_results();
        stop_offering();
        while (expected_factors.size() != 0) @(posedge i_clk);
    endtask

    // Mostly products of small factors with a modest cofactor, so that the
    // search ends quickly; a few carry a cofactor large enough to run long.
    function automatic logic [FIELD_BITS-1:0] random_value();
        logic [63:0] value;
        logic [63:0] factor;
        int          kind;
        int          steps;
        kind = $urandom_range(0, 19);
        if (kind == 0) return FIELD_BITS'($urandom_range(1, 255));
        if (kind == 1) value = 64'($urandom_range(262144, 1048575));
        else value = 64'($urandom_range(1, 16383));
        steps = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        repeat (steps) begin
            factor = 64'($urandom_range(2, 40));
            if (value * factor < FIELD_LIMIT) value = value * factor;
        end
        return value[FIELD_BITS-1:0];
    endfunction

    task automatic test_directed_values();
        logic [FIELD_BITS-1:0] values[19];
        values = '{
            48'd0, 48'd1, 48'd2, 48'd3, 48'd4, 48'd6, 48'd9, 48'd49, 48'd63001,
            48'd7420738134810, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF,
            48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'd205891132094649,
            48'd1040399, 48'd1048573, 48'h7FFF_E800_0000, 48'hC000_0000_0000
        };
        foreach (values[i]) send_value(values[i], 1'b1);
    endtask

    task automatic test_random_factorizations();
        repeat (55) send_value(random_value(), 1'b1);
    endtask

    task automatic test_output_hold_off();
        hold_len    <= 3000;
        hold_serial <= hold_serial + 1;
        repeat (16) send_value(FIELD_BITS'($urandom_range(1, 4095)), 1'b0);
    endtask

    task automatic test_sender_pause();
        repeat (5) send_value(random_value(), 1'b1);
        wait_for_results();
        repeat (5) send_value(random_value(), 1'b0);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_values();
        test_random_factorizations();
        test_output_hold_off();
        test_sender_pause();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_factors.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/trdf_pkg.sv
src/trial_division_factorizer_top.sv
tb/sv/trial_division_factorizer_top_test.sv
